// ===== hdl/supersampled_triangle_coverage_assert.svh =====
// assertion macros used by the triangle coverage cell module
`ifndef SUPERSAMPLED_TRIANGLE_COVERAGE_ASSERT_SVH
`define SUPERSAMPLED_TRIANGLE_COVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

`define SSTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sstc assertion failed");

`define SSTC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sstc assertion failed");

`else

`define SSTC_ASSERT(lbl, clk, rst_n, prop)

`define SSTC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/sstc_pkg.sv =====
// shared types and constants of the supersampled triangle coverage block
package sstc_pkg;

  localparam int PIX_W      = 5;
  localparam int SIDE_W     = 6;
  localparam int DIR_W      = 2;
  localparam int ALPHA_W    = 8;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam int DEF_MAX_SIDE    = 32;
  localparam int DEF_SUBSAMPLES  = 4;

  localparam logic [SIDE_W-1:0] BOX_WIDTH_RST  = 6'd16;
  localparam logic [SIDE_W-1:0] BOX_HEIGHT_RST = 6'd16;

  typedef enum logic [DIR_W-1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_HEIGHT = 2'd1,
    CFG_DIRECTION  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [DIR_W-1:0]  dir;
  } shape_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             outside;
  } beat_t;

endpackage

// ===== hdl/sstc_cell.sv =====
// one subsample cell: tests its sample point and adds the hit to the running count
`include "supersampled_triangle_coverage_assert.svh"

module sstc_cell
  import sstc_pkg::*;
#(
  parameter int S     = DEF_SUBSAMPLES,
  parameter int SX    = 0,
  parameter int SY    = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  shape_t           shape,
  input  logic             up_valid,
  output logic             up_ready,
  input  beat_t            up_beat,
  input  logic [CNT_W-1:0] up_count,
  output logic             dn_valid,
  input  logic             dn_ready,
  output beat_t            dn_beat,
  output logic [CNT_W-1:0] dn_count
);

  localparam int K   = 2 * S;
  localparam int MW  = $clog2(K) + 8;
  localparam int PW  = MW + SIDE_W;
  localparam int IDX = SY * S + SX;

  logic             valid_r;
  beat_t            beat_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic [MW-1:0]     xs, ys, kw, kh;
  logic [MW-1:0]     pos, other, kpos, kother;
  logic [MW-1:0]     pos2, diff, rhs_base;
  logic [SIDE_W-1:0] ext_pos, ext_other;
  logic              base_ok;
  logic [PW-1:0]     lhs, rhs;
  logic              hit;

  always_comb begin
    xs = MW'(K * int'(up_beat.pixel_x) + 2 * SX + 1);
    ys = MW'(K * int'(up_beat.pixel_y) + 2 * SY + 1);
    kw = MW'(K * int'(shape.w));
    kh = MW'(K * int'(shape.h));
    if (shape.dir == DIR_RIGHT) begin
      pos       = ys;
      kpos      = kh;
      ext_pos   = shape.h;
      other     = xs;
      kother    = kw;
      ext_other = shape.w;
    end else begin
      pos       = xs;
      kpos      = kw;
      ext_pos   = shape.w;
      other     = ys;
      kother    = kh;
      ext_other = shape.h;
    end
    pos2 = {pos[MW-2:0], 1'b0};
    diff = (pos2 >= kpos) ? (pos2 - kpos) : (kpos - pos2);
    base_ok = (other <= kother);
    if (shape.dir == DIR_UP) begin
      rhs_base = other;
    end else begin
      rhs_base = kother - other;
    end
    lhs = PW'(diff) * PW'(ext_other);
    rhs = PW'(rhs_base) * PW'(ext_pos);
    hit = base_ok && (lhs <= rhs) && !up_beat.outside;
    count_nxt = up_count + CNT_W'(hit);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r  <= up_beat;
      count_r <= count_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;
  assign dn_count = count_r;

  `SSTC_ASSERT(a_stall_holds, clk, rst_n,
    valid_r && !dn_ready |=> valid_r && $stable(count_r) && $stable(beat_r))
  `SSTC_ASSERT(a_count_bound, clk, rst_n, valid_r |-> count_r <= CNT_W'(IDX + 1))
  `SSTC_ASSERT(a_outside_zero, clk, rst_n, valid_r && beat_r.outside |-> count_r == '0)

endmodule

// ===== hdl/sstc_out_stage.sv =====
// result register: turns the final count into alpha and holds the result beat
module sstc_out_stage
  import sstc_pkg::*;
#(
  parameter int S     = DEF_SUBSAMPLES,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  beat_t              up_beat,
  input  logic [CNT_W-1:0]   up_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ALPHA_W-1:0] out_alpha,
  output logic [COUNT_W-1:0] out_coverage_count,
  output logic               out_outside_box
);

  localparam int N       = S * S;
  localparam int TAB_LEN = 2 ** CNT_W;

  logic [ALPHA_W-1:0] alpha_tab [TAB_LEN];

  for (genvar c = 0; c < TAB_LEN; c++) begin : g_tab
    localparam int A = (510 * c + N) / (2 * N);
    assign alpha_tab[c] = ALPHA_W'((A > 255) ? 255 : A);
  end

  logic               valid_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [COUNT_W-1:0] count_r;
  logic               outside_r;

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      alpha_r   <= alpha_tab[up_count];
      count_r   <= COUNT_W'(up_count);
      outside_r <= up_beat.outside;
    end
  end

  assign out_valid          = valid_r;
  assign out_alpha          = alpha_r;
  assign out_coverage_count = count_r;
  assign out_outside_box    = outside_r;

endmodule

// ===== hdl/supersampled_triangle_coverage.sv =====
// top level of the supersampled triangle coverage block
//
//  channel | signals                                   | role
//  in      | in_valid in_ready in_pixel_x in_pixel_y  | pixel coordinate beat
//  out     | out_valid out_ready out_alpha             | alpha, count and box flag
//          | out_coverage_count out_outside_box        |
//  cfg     | cfg_wr_en cfg_index cfg_wdata             | box size and direction writes
//
// one beat per cycle unless out_ready stalls the chain; one register per subsample cell plus the result register
// every cell tests one sample point, so the cell count sets the latency, not the rate
// reset empties the chain and loads width 16, height 16, direction down
// out_ready low holds every full stage back to the first empty one in the same cycle
// empty stages keep accepting, so bubbles close up while the output stalls
module supersampled_triangle_coverage
  import sstc_pkg::*;
#(
  parameter int MAX_SIDE            = DEF_MAX_SIDE,
  parameter int SUBSAMPLES_PER_AXIS = DEF_SUBSAMPLES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_pixel_x,
  input  logic [PIX_W-1:0]      in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ALPHA_W-1:0]    out_alpha,
  output logic [COUNT_W-1:0]    out_coverage_count,
  output logic                  out_outside_box
);

  localparam int S     = SUBSAMPLES_PER_AXIS;
  localparam int N     = S * S;
  localparam int CNT_W = $clog2(N + 1);
  localparam int SIDE_MAX_REG = 2 ** SIDE_W - 1;
  localparam int SAT   = (MAX_SIDE < SIDE_MAX_REG) ? MAX_SIDE : SIDE_MAX_REG;

  logic [SIDE_W-1:0] box_width_r;
  logic [SIDE_W-1:0] box_height_r;
  logic [DIR_W-1:0]  direction_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_width_r  <= BOX_WIDTH_RST;
      box_height_r <= BOX_HEIGHT_RST;
      direction_r  <= DIR_DOWN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BOX_WIDTH:  box_width_r  <= cfg_wdata;
        CFG_BOX_HEIGHT: box_height_r <= cfg_wdata;
        CFG_DIRECTION:  direction_r  <= cfg_wdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  shape_t shape;

  always_comb begin
    shape.w = (box_width_r > SIDE_W'(SAT)) ? SIDE_W'(SAT) : box_width_r;
    shape.h = (box_height_r > SIDE_W'(SAT)) ? SIDE_W'(SAT) : box_height_r;
    unique case (direction_r)
      DIR_RIGHT: shape.dir = DIR_RIGHT;
      DIR_UP:    shape.dir = DIR_UP;
      default:   shape.dir = DIR_DOWN;
    endcase
  end

  logic             ch_valid [N+1];
  logic             ch_ready [N+1];
  beat_t            ch_beat  [N+1];
  logic [CNT_W-1:0] ch_count [N+1];

  assign ch_valid[0]         = in_valid;
  assign in_ready            = ch_ready[0];
  assign ch_beat[0].pixel_x  = in_pixel_x;
  assign ch_beat[0].pixel_y  = in_pixel_y;
  assign ch_beat[0].outside  = (SIDE_W'(in_pixel_x) >= shape.w) ||
                               (SIDE_W'(in_pixel_y) >= shape.h);
  assign ch_count[0]         = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sstc_cell #(
      .S     (S),
      .SX    (i % S),
      .SY    (i / S),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shape    (shape),
      .up_valid (ch_valid[i]),
      .up_ready (ch_ready[i]),
      .up_beat  (ch_beat[i]),
      .up_count (ch_count[i]),
      .dn_valid (ch_valid[i+1]),
      .dn_ready (ch_ready[i+1]),
      .dn_beat  (ch_beat[i+1]),
      .dn_count (ch_count[i+1])
    );
  end

  sstc_out_stage #(
    .S     (S),
    .CNT_W (CNT_W)
  ) u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (ch_valid[N]),
    .up_ready           (ch_ready[N]),
    .up_beat            (ch_beat[N]),
    .up_count           (ch_count[N]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_alpha          (out_alpha),
    .out_coverage_count (out_coverage_count),
    .out_outside_box    (out_outside_box)
  );

endmodule
